>>> src/tts_pkg.sv
// tts_pkg: shared types and constants for the triangle tangent space unit
// no dependencies; imported by every module of the block

package tts_pkg;

    localparam int COORD_WIDTH_DEF = 32;   // default coordinate width, Q16.16
    localparam int UNIT_W          = 16;   // width of a Q1.14 unit component
    localparam int FRAC_BITS       = 14;   // fraction bits of Q1.14
    localparam int NORM_BITS       = 30;   // aligned mantissa lies in [2^29, 2^30)
    localparam int QUOT_BITS       = 15;   // quotient bits of one normalize division
    localparam int ROOT_W          = 32;   // width of the vector length
    localparam int SUMSQ_W         = 64;   // width of the sum of squares
    localparam int NUM_FIELDS      = 5;    // x, y, z, u, v

    localparam logic signed [UNIT_W-1:0] UNIT_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic load;
        logic shift;
    } scale_ctl_t;

    typedef struct packed {
        logic zero;
        logic aligned;
    } scale_stat_t;

    typedef enum logic [1:0] {
        K_DET,
        K_TAN,
        K_BIN,
        K_NRM
    } vec_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD_GO,
        ST_PROD_WAIT,
        ST_NORM_LOAD,
        ST_NORM_SHIFT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } seq_state_t;

endpackage

>>> src/tts_if.sv
// tts_vtx_if and tts_res_if: valid/ready channels of the tangent space unit
// no dependencies; the unit component width is written out as 16 bits

interface tts_vtx_if #(
    parameter int CW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tts_res_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                    binormal_z, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                    binormal_z, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

>>> src/tts_alu.sv
// tts_alu: shared bit-serial unit, one add or subtract per cycle
// multiply (shift-add), restoring divide and digit-by-digit square root; uses tts_pkg

module tts_alu
    import tts_pkg::*;
#(
    parameter int MA = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [2*MA-1:0]   opnd_a,
    input  logic [MA-1:0]     opnd_b,
    output alu_stat_t         stat,
    output logic [2*MA-1:0]   result
);

    localparam int PW    = 2 * MA;
    localparam int CNT_W = $clog2(MA);

    alu_op_t          op_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    aux_reg;
    logic [PW-1:0]    res_reg;

    logic [PW-1:0]    x_op;
    logic [PW-1:0]    y_op;
    logic             sub;
    logic [PW:0]      sum;
    logic             ge;

    // the one adder of the block
    always_comb
    begin
        x_op = '0;
        y_op = '0;
        sub  = 1'b0;
        unique case (op_reg)
            ALU_MUL:
            begin
                x_op = PW'(acc_reg[PW-1:MA]);
                y_op = acc_reg[0] ? res_reg : '0;
            end
            ALU_DIV:
            begin
                x_op = acc_reg;
                y_op = aux_reg;
                sub  = 1'b1;
            end
            ALU_SQRT:
            begin
                x_op = acc_reg;
                y_op = res_reg | aux_reg;
                sub  = 1'b1;
            end
            default:
            begin
                x_op = '0;
            end
        endcase
        sum = sub ? ({1'b0, x_op} - {1'b0, y_op}) : ({1'b0, x_op} + {1'b0, y_op});
        ge  = ~sum[PW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= ALU_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == ALU_DIV) ? CNT_W'(QUOT_BITS - 1) : CNT_W'(MA - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            unique case (req.op)
                ALU_MUL:
                begin
                    acc_reg <= PW'(opnd_a[MA-1:0]);
                    res_reg <= PW'(opnd_b);
                end
                ALU_DIV:
                begin
                    acc_reg <= opnd_a;
                    aux_reg <= PW'(opnd_b) << (QUOT_BITS - 1);
                    res_reg <= '0;
                end
                ALU_SQRT:
                begin
                    acc_reg <= opnd_a;
                    aux_reg <= PW'(1) << (PW - 2);
                    res_reg <= '0;
                end
                default:
                begin
                    acc_reg <= opnd_a;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    acc_reg <= {sum[MA:0], acc_reg[MA-1:1]};
                end
                ALU_DIV:
                begin
                    if (ge)
                    begin
                        acc_reg <= sum[PW-1:0];
                    end
                    res_reg <= {res_reg[PW-2:0], ge};
                    aux_reg <= aux_reg >> 1;
                end
                ALU_SQRT:
                begin
                    if (ge)
                    begin
                        acc_reg <= sum[PW-1:0];
                        res_reg <= (res_reg >> 1) | aux_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    aux_reg <= aux_reg >> 2;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == ALU_MUL) ? acc_reg : res_reg;

endmodule

>>> src/tts_scale.sv
// tts_scale: aligns three magnitudes one bit a cycle while shift is set, until the largest is in [2^29, 2^30)
// uses tts_pkg for the control and status structs

module tts_scale
    import tts_pkg::*;
#(
    parameter int MW = 66
) (
    input  logic                          clk,
    input  scale_ctl_t                    ctl,
    input  logic [2:0][MW-1:0]            mag_in,
    output scale_stat_t                   stat,
    output logic [2:0][NORM_BITS-1:0]     mant
);

    logic [2:0][MW-1:0] m_reg;
    logic [MW-1:0]      all_or;
    logic               too_high;

    assign all_or   = m_reg[0] | m_reg[1] | m_reg[2];
    assign too_high = |all_or[MW-1:NORM_BITS];

    assign stat.zero    = (all_or == '0);
    assign stat.aligned = !too_high && all_or[NORM_BITS-1];

    // right shifts truncate each magnitude, left shifts are exact
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            m_reg <= mag_in;
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= too_high ? (m_reg[i] >> 1) : (m_reg[i] << 1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mant[i] = m_reg[i][NORM_BITS-1:0];
        end
    end

endmodule

>>> src/triangle_tangent_space_unit.sv
// triangle_tangent_space_unit: per-face tangent, binormal and normal from a vertex stream
// depends on tts_pkg, tts_if, tts_alu and tts_scale
//
// Vertices arrive as signed Q16.16 position and texture coordinates. The first two
// vertices of a triangle are held. The third starts the face computation and the
// input stays not ready until it is done: two determinant products, then for each
// of the three vectors (tangent, binormal, normal cross) six signed products, an
// alignment shift of one bit per cycle, three squares, a square root and three
// divisions, twenty products in all. Products, squares, root and divisions run on
// one bit-serial unit that retires one bit per cycle. The result is held in an
// output register so the next vertices are taken while it waits. A zero determinant
// or a zero vector gives all-zero vectors with degenerate set. Outputs are signed
// Q1.14.

module triangle_tangent_space_unit
    import tts_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    tts_vtx_if.sink  vtx,
    tts_res_if.source res
);

    localparam int CW = COORD_WIDTH;
    localparam int OW = CW + 1;
    localparam int MA = (OW > ROOT_W) ? OW : ROOT_W;
    localparam int PW = 2 * MA;
    localparam int VW = PW + 1;

    seq_state_t state_reg, state_next;
    vec_kind_t  kind_reg;
    logic [1:0] comp_reg;
    logic       second_reg;
    logic       deg_reg;
    logic [1:0] corner_cnt_reg;
    logic       out_valid_reg;

    logic signed [CW-1:0] c1_reg [NUM_FIELDS];
    logic signed [CW-1:0] c2_reg [NUM_FIELDS];
    logic signed [CW-1:0] cur [NUM_FIELDS];
    logic signed [OW-1:0] e1_reg [3];
    logic signed [OW-1:0] e2_reg [3];
    logic signed [OW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic                 psign_reg;
    logic signed [VW-1:0] sp1_reg;
    logic                 det_neg_reg;
    logic signed [VW-1:0] vec_reg [3];
    logic [2:0]           neg_reg;
    logic [SUMSQ_W-1:0]   s_reg;
    logic [ROOT_W-1:0]    len_reg;
    logic signed [UNIT_W-1:0] tan_reg [3];
    logic signed [UNIT_W-1:0] bin_reg [3];
    logic signed [UNIT_W-1:0] nrm_reg [3];
    logic signed [UNIT_W-1:0] out_reg [9];
    logic                 out_deg_reg;

    logic                 vtx_acc;
    logic                 emit_ok;
    logic [1:0]           j_idx, k_idx;
    logic signed [OW-1:0] opa, opb;
    logic [OW-1:0]        mag_a, mag_b;
    logic [VW-1:0]        pv;
    logic signed [VW-1:0] sp1_next, combined;
    logic                 combined_zero;
    logic signed [VW-1:0] absv [3];
    logic [2:0][PW-1:0]   mag_in;
    logic [2:0][NORM_BITS-1:0] mant;
    logic [QUOT_BITS-1:0] quot;
    logic signed [UNIT_W-1:0] unit_val;

    alu_req_t    alu_req;
    alu_stat_t   alu_stat;
    logic [PW-1:0] alu_a;
    logic [MA-1:0] alu_b;
    logic [PW-1:0] alu_res;
    scale_ctl_t  scale_ctl;
    scale_stat_t scale_stat;

    tts_alu #(.MA(MA)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opnd_a (alu_a),
        .opnd_b (alu_b),
        .stat   (alu_stat),
        .result (alu_res)
    );

    tts_scale #(.MW(PW)) u_scale (
        .clk    (clk),
        .ctl    (scale_ctl),
        .mag_in (mag_in),
        .stat   (scale_stat),
        .mant   (mant)
    );

    assign cur[0] = vtx.pos_x;
    assign cur[1] = vtx.pos_y;
    assign cur[2] = vtx.pos_z;
    assign cur[3] = vtx.tex_u;
    assign cur[4] = vtx.tex_v;

    assign vtx.ready = (state_reg == ST_IDLE);
    assign vtx_acc   = vtx.valid && vtx.ready;
    assign emit_ok   = !out_valid_reg || res.ready;

    // cross product partners of the current normal component
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                j_idx = 2'd1;
                k_idx = 2'd2;
            end
            2'd1:
            begin
                j_idx = 2'd2;
                k_idx = 2'd0;
            end
            2'd2:
            begin
                j_idx = 2'd0;
                k_idx = 2'd1;
            end
            default:
            begin
                j_idx = 2'd0;
                k_idx = 2'd0;
            end
        endcase
    end

    // operands of the current product
    always_comb
    begin
        unique case (kind_reg)
            K_DET:
            begin
                opa = second_reg ? du2_reg : du1_reg;
                opb = second_reg ? dv1_reg : dv2_reg;
            end
            K_TAN:
            begin
                opa = second_reg ? dv1_reg : dv2_reg;
                opb = second_reg ? e2_reg[comp_reg] : e1_reg[comp_reg];
            end
            K_BIN:
            begin
                opa = second_reg ? du2_reg : du1_reg;
                opb = second_reg ? e1_reg[comp_reg] : e2_reg[comp_reg];
            end
            K_NRM:
            begin
                opa = OW'(tan_reg[second_reg ? k_idx : j_idx]);
                opb = OW'(bin_reg[second_reg ? j_idx : k_idx]);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        mag_a = opa[OW-1] ? OW'(-opa) : OW'(opa);
        mag_b = opb[OW-1] ? OW'(-opb) : OW'(opb);
    end

    // signed accumulation of the two products of one term
    always_comb
    begin
        pv            = {1'b0, alu_res};
        sp1_next      = psign_reg ? -$signed(pv) : $signed(pv);
        combined      = psign_reg ? (sp1_reg + $signed(pv)) : (sp1_reg - $signed(pv));
        combined_zero = (combined == '0);
        for (int i = 0; i < 3; i++)
        begin
            absv[i]   = vec_reg[i][VW-1] ? -vec_reg[i] : vec_reg[i];
            mag_in[i] = absv[i][PW-1:0];
        end
        quot     = alu_res[QUOT_BITS-1:0];
        unit_val = neg_reg[comp_reg] ? -$signed(UNIT_W'(quot)) : $signed(UNIT_W'(quot));
    end

    always_comb
    begin
        state_next      = state_reg;
        alu_req.start   = 1'b0;
        alu_req.op      = ALU_MUL;
        alu_a           = '0;
        alu_b           = '0;
        scale_ctl.load  = 1'b0;
        scale_ctl.shift = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (vtx_acc && corner_cnt_reg == 2'd2)
                begin
                    state_next = ST_PROD_GO;
                end
            end
            ST_PROD_GO:
            begin
                alu_req.start = 1'b1;
                alu_a         = PW'(mag_a);
                alu_b         = MA'(mag_b);
                state_next    = ST_PROD_WAIT;
            end
            ST_PROD_WAIT:
            begin
                if (alu_stat.done)
                begin
                    if (!second_reg)
                    begin
                        state_next = ST_PROD_GO;
                    end
                    else if (kind_reg == K_DET)
                    begin
                        state_next = combined_zero ? ST_EMIT : ST_PROD_GO;
                    end
                    else if (comp_reg == 2'd2)
                    begin
                        state_next = ST_NORM_LOAD;
                    end
                    else
                    begin
                        state_next = ST_PROD_GO;
                    end
                end
            end
            ST_NORM_LOAD:
            begin
                scale_ctl.load = 1'b1;
                state_next     = ST_NORM_SHIFT;
            end
            ST_NORM_SHIFT:
            begin
                if (scale_stat.zero)
                begin
                    state_next = ST_EMIT;
                end
                else if (scale_stat.aligned)
                begin
                    state_next = ST_SQ_GO;
                end
                else
                begin
                    scale_ctl.shift = 1'b1;
                end
            end
            ST_SQ_GO:
            begin
                alu_req.start = 1'b1;
                alu_a         = PW'(mant[comp_reg]);
                alu_b         = MA'(mant[comp_reg]);
                state_next    = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = (comp_reg == 2'd2) ? ST_ROOT_GO : ST_SQ_GO;
                end
            end
            ST_ROOT_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_a         = PW'(s_reg);
                state_next    = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                // rounded quotient: (m * 2^14 + len / 2) / len
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a         = (PW'(mant[comp_reg]) << FRAC_BITS) + PW'(len_reg >> 1);
                alu_b         = MA'(len_reg);
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    if (comp_reg != 2'd2)
                    begin
                        state_next = ST_DIV_GO;
                    end
                    else
                    begin
                        state_next = (kind_reg == K_NRM) ? ST_EMIT : ST_PROD_GO;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= K_DET;
            comp_reg       <= '0;
            second_reg     <= 1'b0;
            deg_reg        <= 1'b0;
            corner_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res.ready && !(state_reg == ST_EMIT && emit_ok))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (vtx_acc)
                    begin
                        corner_cnt_reg <= (corner_cnt_reg == 2'd2) ? 2'd0 : corner_cnt_reg + 1'b1;
                        kind_reg       <= K_DET;
                        comp_reg       <= '0;
                        second_reg     <= 1'b0;
                        deg_reg        <= 1'b0;
                    end
                end
                ST_PROD_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        second_reg <= !second_reg;
                        if (second_reg)
                        begin
                            if (kind_reg == K_DET)
                            begin
                                deg_reg  <= combined_zero;
                                kind_reg <= K_TAN;
                                comp_reg <= '0;
                            end
                            else
                            begin
                                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_NORM_SHIFT:
                begin
                    if (scale_stat.zero)
                    begin
                        deg_reg <= 1'b1;
                    end
                    comp_reg <= '0;
                end
                ST_SQ_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 1'b1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        if (comp_reg == 2'd2)
                        begin
                            comp_reg <= '0;
                            kind_reg <= (kind_reg == K_TAN) ? K_BIN : K_NRM;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    second_reg <= second_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (vtx_acc)
                begin
                    if (corner_cnt_reg == 2'd0)
                    begin
                        for (int f = 0; f < NUM_FIELDS; f++)
                        begin
                            c1_reg[f] <= cur[f];
                        end
                    end
                    else if (corner_cnt_reg == 2'd1)
                    begin
                        for (int f = 0; f < NUM_FIELDS; f++)
                        begin
                            c2_reg[f] <= cur[f];
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_reg[i] <= {c2_reg[i][CW-1], c2_reg[i]} - {c1_reg[i][CW-1], c1_reg[i]};
                            e2_reg[i] <= {cur[i][CW-1], cur[i]} - {c1_reg[i][CW-1], c1_reg[i]};
                        end
                        du1_reg <= {c2_reg[3][CW-1], c2_reg[3]} - {c1_reg[3][CW-1], c1_reg[3]};
                        dv1_reg <= {c2_reg[4][CW-1], c2_reg[4]} - {c1_reg[4][CW-1], c1_reg[4]};
                        du2_reg <= {cur[3][CW-1], cur[3]} - {c1_reg[3][CW-1], c1_reg[3]};
                        dv2_reg <= {cur[4][CW-1], cur[4]} - {c1_reg[4][CW-1], c1_reg[4]};
                    end
                end
            end
            ST_PROD_GO:
            begin
                psign_reg <= opa[OW-1] ^ opb[OW-1];
            end
            ST_PROD_WAIT:
            begin
                if (alu_stat.done)
                begin
                    if (!second_reg)
                    begin
                        sp1_reg <= sp1_next;
                    end
                    else if (kind_reg == K_DET)
                    begin
                        det_neg_reg <= combined[VW-1];
                    end
                    else
                    begin
                        vec_reg[comp_reg] <= combined;
                    end
                end
            end
            ST_NORM_LOAD:
            begin
                // only the sign of the determinant matters for tangent and binormal
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec_reg[i][VW-1] ^ (det_neg_reg && kind_reg != K_NRM);
                end
            end
            ST_SQ_WAIT:
            begin
                if (alu_stat.done)
                begin
                    s_reg <= ((comp_reg == 2'd0) ? '0 : s_reg) + alu_res[SUMSQ_W-1:0];
                end
            end
            ST_ROOT_WAIT:
            begin
                if (alu_stat.done)
                begin
                    len_reg <= alu_res[ROOT_W-1:0];
                end
            end
            ST_DIV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    unique case (kind_reg)
                        K_TAN:   tan_reg[comp_reg] <= unit_val;
                        K_BIN:   bin_reg[comp_reg] <= unit_val;
                        K_NRM:   nrm_reg[comp_reg] <= unit_val;
                        default: nrm_reg[comp_reg] <= unit_val;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_reg[i]     <= deg_reg ? '0 : tan_reg[i];
                        out_reg[3 + i] <= deg_reg ? '0 : bin_reg[i];
                        out_reg[6 + i] <= deg_reg ? '0 : nrm_reg[i];
                    end
                    out_deg_reg <= deg_reg;
                end
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

    assign res.valid      = out_valid_reg;
    assign res.tangent_x  = out_reg[0];
    assign res.tangent_y  = out_reg[1];
    assign res.tangent_z  = out_reg[2];
    assign res.binormal_x = out_reg[3];
    assign res.binormal_y = out_reg[4];
    assign res.binormal_z = out_reg[5];
    assign res.normal_x   = out_reg[6];
    assign res.normal_y   = out_reg[7];
    assign res.normal_z   = out_reg[8];
    assign res.degenerate = out_deg_reg;

    // the serial unit is never restarted while it still works
    a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_stat.busy)
        else $error("serial unit started while busy");

    // a third vertex transfer closes the input until the face is done
    a_third_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (vtx_acc && corner_cnt_reg == 2'd2) |=> !vtx.ready)
        else $error("input ready right after a third vertex");

    // a degenerate face carries zero vectors, sampled on tangent_x, binormal_y and normal_z
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.degenerate) |-> (res.tangent_x == '0 && res.binormal_y == '0
            && res.normal_z == '0))
        else $error("degenerate result with nonzero vector");

    // unit components never exceed one in magnitude, sampled on normal_x and tangent_y
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.normal_x <= UNIT_ONE && res.normal_x >= -UNIT_ONE
            && res.tangent_y <= UNIT_ONE && res.tangent_y >= -UNIT_ONE))
        else $error("unit component out of range");

endmodule

>>> dv/tts_face_checker.sv
`timescale 1ns / 1ps
// tts_face_checker: watches the vertex and result channels of the tangent space unit,
// predicts the face frame of every third vertex and compares it field by field
// depends on tts_pkg and the tts_vtx_if / tts_res_if interfaces

module tts_face_checker
    import tts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tts_vtx_if   vtx,
    tts_res_if   res,
    output int   fails,
    output int   pending
);

    typedef struct {
        logic signed [UNIT_W-1:0] tan [3];
        logic signed [UNIT_W-1:0] bin [3];
        logic signed [UNIT_W-1:0] nrm [3];
        logic                     degenerate;
    } face_frame_t;

    typedef logic signed [127:0] wide_t;

    face_frame_t      frame_q[$];
    logic signed [127:0] corner [2][NUM_FIELDS];
    int               corners_held;

    assign pending = frame_q.size();

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // scale to unit length in Q1.14; returns 0 for a zero vector
    function automatic logic to_unit(input wide_t a, input wide_t b, input wide_t c,
                                     output logic signed [15:0] oa,
                                     output logic signed [15:0] ob,
                                     output logic signed [15:0] oc);
        wide_t       v [3];
        wide_t       mag [3];
        logic [63:0] m [3];
        logic [63:0] sumsq, len, q;
        int          maxbl;
        v[0] = a; v[1] = b; v[2] = c;
        maxbl = 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            for (int k = 0; k < 128; k++)
                if (mag[i][k] && k + 1 > maxbl) maxbl = k + 1;
        end
        oa = 0; ob = 0; oc = 0;
        if (maxbl == 0) return 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (maxbl > NORM_BITS) m[i] = 64'(mag[i] >> (maxbl - NORM_BITS));
            else                   m[i] = 64'(mag[i] << (NORM_BITS - maxbl));
            sumsq = sumsq + m[i] * m[i];
        end
        len = isqrt64(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 64'd16384 + len / 2) / len;
            if (v[i] < 0) q = -q;
            if (i == 0) oa = q[15:0];
            else if (i == 1) ob = q[15:0];
            else oc = q[15:0];
        end
        return 1'b1;
    endfunction

    function automatic face_frame_t predict_frame(input wide_t p [NUM_FIELDS]);
        face_frame_t f;
        wide_t       e1 [3];
        wide_t       e2 [3];
        wide_t       tv [3];
        wide_t       bv [3];
        wide_t       du1, dv1, du2, dv2, det;
        longint      n0, n1, n2;
        logic        ok;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = corner[1][i] - corner[0][i];
            e2[i] = p[i] - corner[0][i];
        end
        du1 = corner[1][3] - corner[0][3];
        dv1 = corner[1][4] - corner[0][4];
        du2 = p[3] - corner[0][3];
        dv2 = p[4] - corner[0][4];
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++)
        begin
            tv[i] = dv2 * e1[i] - dv1 * e2[i];
            bv[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0)
            begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        ok = det != 0;
        for (int i = 0; i < 3; i++)
        begin
            f.tan[i] = 0; f.bin[i] = 0; f.nrm[i] = 0;
        end
        if (ok) ok = to_unit(tv[0], tv[1], tv[2], f.tan[0], f.tan[1], f.tan[2]);
        if (ok) ok = to_unit(bv[0], bv[1], bv[2], f.bin[0], f.bin[1], f.bin[2]);
        if (ok)
        begin
            n0 = longint'(f.tan[1]) * f.bin[2] - longint'(f.tan[2]) * f.bin[1];
            n1 = longint'(f.tan[2]) * f.bin[0] - longint'(f.tan[0]) * f.bin[2];
            n2 = longint'(f.tan[0]) * f.bin[1] - longint'(f.tan[1]) * f.bin[0];
            ok = to_unit(wide_t'(n0), wide_t'(n1), wide_t'(n2),
                         f.nrm[0], f.nrm[1], f.nrm[2]);
        end
        if (!ok)
            for (int i = 0; i < 3; i++)
            begin
                f.tan[i] = 0; f.bin[i] = 0; f.nrm[i] = 0;
            end
        f.degenerate = !ok;
        return f;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge clk or negedge rst_n)
    begin
        wide_t       vin [NUM_FIELDS];
        face_frame_t want;
        if (!rst_n)
        begin
            corners_held <= 0;
            for (int c = 0; c < 2; c++)
                for (int i = 0; i < NUM_FIELDS; i++)
                    corner[c][i] <= 0;
        end
        else
        begin
            if (vtx.valid && vtx.ready)
            begin
                vin[0] = vtx.pos_x; vin[1] = vtx.pos_y; vin[2] = vtx.pos_z;
                vin[3] = vtx.tex_u; vin[4] = vtx.tex_v;
                if (corners_held < 2)
                begin
                    for (int i = 0; i < NUM_FIELDS; i++)
                        corner[corners_held][i] <= vin[i];
                    corners_held <= corners_held + 1;
                end
                else
                begin
                    frame_q.push_back(predict_frame(vin));
                    corners_held <= 0;
                end
            end
            if (res.valid && res.ready)
            begin
                if (frame_q.size() == 0)
                begin
                    report_mismatch("result transfer with no face outstanding", 1, 0);
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (res.tangent_x !== want.tan[0])
                        report_mismatch("tangent_x", res.tangent_x, want.tan[0]);
                    if (res.tangent_y !== want.tan[1])
                        report_mismatch("tangent_y", res.tangent_y, want.tan[1]);
                    if (res.tangent_z !== want.tan[2])
                        report_mismatch("tangent_z", res.tangent_z, want.tan[2]);
                    if (res.binormal_x !== want.bin[0])
                        report_mismatch("binormal_x", res.binormal_x, want.bin[0]);
                    if (res.binormal_y !== want.bin[1])
                        report_mismatch("binormal_y", res.binormal_y, want.bin[1]);
                    if (res.binormal_z !== want.bin[2])
                        report_mismatch("binormal_z", res.binormal_z, want.bin[2]);
                    if (res.normal_x !== want.nrm[0])
                        report_mismatch("normal_x", res.normal_x, want.nrm[0]);
                    if (res.normal_y !== want.nrm[1])
                        report_mismatch("normal_y", res.normal_y, want.nrm[1]);
                    if (res.normal_z !== want.nrm[2])
                        report_mismatch("normal_z", res.normal_z, want.nrm[2]);
                    if (res.degenerate !== want.degenerate)
                        report_mismatch("degenerate", res.degenerate, want.degenerate);
                end
            end
        end
    end

endmodule

>>> dv/tb_triangle_tangent_space_unit.sv
`timescale 1ns / 1ps
// tb_triangle_tangent_space_unit: vertex stimulus, result back-pressure and verdict
// depends on tts_pkg, tts_if, the unit itself and tts_face_checker

module tb_triangle_tangent_space_unit
    import tts_pkg::*;
();

    localparam int  NUM_FACES   = 600;
    localparam int  STALL_LEN   = 6000;
    localparam longint CYCLE_CAP = 8_000_000;

    logic   clk;
    logic   rst_n;
    int     fails;
    int     pending;
    int     hold_left;
    longint cycles;

    tts_vtx_if #(.CW(COORD_WIDTH_DEF)) vtx ();
    tts_res_if res ();

    triangle_tangent_space_unit #(.COORD_WIDTH(COORD_WIDTH_DEF)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .res   (res)
    );

    tts_face_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .vtx     (vtx),
        .res     (res),
        .fails   (fails),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout with %0d faces outstanding", pending);
            $display("tb_triangle_tangent_space_unit failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ($urandom_range(0, 99) < 3)
            res.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 25)
            res.ready <= 1'b0;
        else
            res.ready <= 1'b1;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] u,
                               input logic [31:0] v);
        int gap;
        vtx.pos_x <= x; vtx.pos_y <= y; vtx.pos_z <= z;
        vtx.tex_u <= u; vtx.tex_v <= v;
        vtx.valid <= 1'b1;
        do @(posedge clk); while (!vtx.ready);
        gap = idle_len();
        if (gap > 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        if (r < 85) return $urandom;
        if (r < 92) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return 32'($urandom_range(0, 4)) - 32'd2;
    endfunction

    task automatic send_random_face();
        logic [31:0] f [3][5];
        int          shape;
        shape = $urandom_range(0, 99);
        for (int c = 0; c < 3; c++)
            for (int i = 0; i < 5; i++)
                f[c][i] = rand_coord();
        // some faces share texture deltas or positions so degenerate cases recur
        if (shape < 6)
        begin
            f[2][3] = f[0][3]; f[2][4] = f[0][4];
        end
        else if (shape < 10)
        begin
            f[1][3] = f[0][3]; f[2][3] = f[0][3];
        end
        else if (shape < 13)
            for (int i = 0; i < 3; i++) f[2][i] = f[1][i];
        for (int c = 0; c < 3; c++)
            send_vertex(f[c][0], f[c][1], f[c][2], f[c][3], f[c][4]);
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    initial
    begin
        cycles    = 0;
        hold_left = 0;
        rst_n     = 1'b0;
        vtx.valid = 1'b0;
        vtx.pos_x = 0; vtx.pos_y = 0; vtx.pos_z = 0;
        vtx.tex_u = 0; vtx.tex_v = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain right triangle in the xy plane
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(ONE, 0, 0, ONE, 0);
        send_vertex(0, ONE, 0, 0, ONE);
        // mirrored texture gives a negative determinant
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(ONE, 0, 0, -ONE, 0);
        send_vertex(0, ONE, 0, 0, ONE);
        // zero determinant: all texture coordinates equal
        send_vertex(ONE, 2, 3, 7, 7);
        send_vertex(5, ONE, 9, 7, 7);
        send_vertex(1, 1, ONE, 7, 7);
        // zero tangent and binormal: all positions equal
        send_vertex(3, 3, 3, 0, 0);
        send_vertex(3, 3, 3, ONE, 0);
        send_vertex(3, 3, 3, 0, ONE);
        // field extremes
        send_vertex(NMIN, NMIN, NMIN, NMIN, NMIN);
        send_vertex(PMAX, PMAX, NMIN, PMAX, NMIN);
        send_vertex(NMIN, PMAX, PMAX, NMIN, PMAX);
        send_vertex(PMAX, NMIN, PMAX, PMAX, PMAX);
        send_vertex(NMIN, PMAX, NMIN, NMIN, NMIN);
        send_vertex(PMAX, PMAX, PMAX, PMAX, NMIN);
        // tiny coordinates, one lsb apart
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(1, 0, 0, 1, 0);
        send_vertex(0, 0, 1, 0, 1);

        for (int n = 0; n < NUM_FACES; n++)
        begin
            if (n == NUM_FACES / 4)
                hold_left = STALL_LEN;
            if (n == NUM_FACES / 2)
            begin
                vtx.valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
            end
            send_random_face();
        end
        vtx.valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (2000) @(posedge clk);
        if (fails == 0)
            $display("tb_triangle_tangent_space_unit passed");
        else
            $display("tb_triangle_tangent_space_unit failed");
        $finish;
    end

endmodule
